[hdl/ppd_pkg.sv]
package ppd_pkg;

    // Command codes on i_command
    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_DISPATCH = 3'd1;
    localparam logic [2:0] CMD_FINISH   = 3'd2;
    localparam logic [2:0] CMD_DELAY    = 3'd3;
    localparam logic [2:0] CMD_DELETE   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Priority that is never started; also the starting value of the minimum search
    localparam logic [15:0] PRIO_NONE = 16'hffff;

    typedef enum logic [1:0] {
        MODE_SUSP    = 2'd0,
        MODE_READY   = 2'd1,
        MODE_RUN     = 2'd2,
        MODE_TIMEOUT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DISP,
        S_PICK,
        S_RD,
        S_WR,
        S_DONE
    } t_state;

    // One slot of the task table as held in RAM
    typedef struct packed {
        logic [31:0] period;
        logic [15:0] priority_val;
        logic [31:0] budget;
        logic [31:0] start_time;
        logic [31:0] sleep;
        logic [31:0] runs;
    } t_slot_word;

    localparam int SLOT_W = $bits(t_slot_word);

endpackage

[hdl/ppd_ram.sv]
module ppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/periodic_priority_task_dispatcher_top.sv]
// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+-------------------------------------------
// command  | in        | start high, busy low | i_command, i_now_time, i_period,
//          |           |                      | i_priority_req, i_max_time, i_delay,
//          |           |                      | i_task_slot
// result   | out       | o_done, one cycle    | o_status, o_chosen_slot, o_overran
//
// Every command walks a small sequencer; busy stays high through the result cycle.
// Dispatch makes one table RAM read per slot through one shared ready/compare unit; add
// scans for the first free slot. Finish and delay do a read-modify-write of one RAM word;
// other commands go straight from idle to the result state.
// Reset is synchronous, active low; the table RAM needs no clearing pass.
// The receiver cannot stall: o_done is high for exactly one cycle per command.
module periodic_priority_task_dispatcher_top #(
    parameter int TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_period,
    input  logic [15:0] i_priority_req,
    input  logic [31:0] i_max_time,
    input  logic [31:0] i_delay,
    input  logic [3:0]  i_task_slot,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_chosen_slot,
    output logic        o_overran
);

    import ppd_pkg::*;

    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [IW:0] LAST = (IW + 1)'(TASKS);

    // Control registers
    t_state          r_state, n_state;
    logic [TASKS-1:0] r_used, n_used;
    t_mode           r_mode [TASKS];
    t_mode           n_mode [TASKS];
    logic            r_run_v, n_run_v;
    logic [IW-1:0]   r_run_idx, n_run_idx;
    logic [31:0]     r_deadline, n_deadline;
    logic [IW:0]     r_idx, n_idx;
    logic            r_found, n_found;
    logic [1:0]      r_status, n_status;
    logic [3:0]      r_chosen, n_chosen;
    logic            r_over, n_over;

    // Payload registers
    logic [2:0]      r_cmd, n_cmd;
    logic [31:0]     r_now, n_now;
    logic [31:0]     r_per, n_per;
    logic [15:0]     r_pri, n_pri;
    logic [31:0]     r_bud, n_bud;
    logic [31:0]     r_dly, n_dly;
    logic [15:0]     r_best, n_best;
    logic [IW-1:0]   r_pick, n_pick;
    logic [31:0]     r_best_bud, n_best_bud;

    // Table RAM port
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    t_slot_word      ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    t_slot_word      rd;

    // Shared compare unit and walk helpers
    logic [IW-1:0]   cur_idx;
    logic [IW-1:0]   eval_idx;
    logic [31:0]     elapsed;
    logic [32:0]     need;
    logic            due;
    logic [31:0]     late_diff;
    logic            late;
    logic            sel_ok;
    logic [IW-1:0]   sel_idx;

    ppd_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_slot_word'(ram_rdata);
    assign cur_idx  = r_idx[IW-1:0];
    assign eval_idx = IW'(r_idx - (IW + 1)'(1));

    // Ready test: elapsed time against sleep plus period, widened so the sum never wraps
    assign elapsed = r_now - rd.start_time;
    assign need    = {1'b0, rd.sleep} + {1'b0, rd.period};
    assign due     = r_used[eval_idx] && ({1'b0, elapsed} >= need);

    // Overrun: now minus deadline is positive as a signed value
    assign late_diff = r_now - r_deadline;
    assign late      = (late_diff != 32'd0) && !late_diff[31];

    assign sel_ok  = ({5'd0, i_task_slot} < 9'(TASKS)) && r_used[IW'(i_task_slot)];
    assign sel_idx = IW'(i_task_slot);

    // Next state, table updates and RAM control
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_mode     = r_mode;
        n_run_v    = r_run_v;
        n_run_idx  = r_run_idx;
        n_deadline = r_deadline;
        n_idx      = r_idx;
        n_found    = r_found;
        n_status   = r_status;
        n_chosen   = r_chosen;
        n_over     = r_over;
        n_cmd      = r_cmd;
        n_now      = r_now;
        n_per      = r_per;
        n_pri      = r_pri;
        n_bud      = r_bud;
        n_dly      = r_dly;
        n_best     = r_best;
        n_pick     = r_pick;
        n_best_bud = r_best_bud;
        ram_we     = 1'b0;
        ram_waddr  = cur_idx;
        ram_wdata  = rd;
        ram_raddr  = cur_idx;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_command;
                    n_now    = i_now_time;
                    n_per    = i_period;
                    n_pri    = i_priority_req;
                    n_bud    = i_max_time;
                    n_dly    = i_delay;
                    n_status = ST_INVALID;
                    n_chosen = 4'd0;
                    n_over   = 1'b0;
                    n_idx    = '0;
                    n_state  = S_DONE;
                    unique case (i_command)
                        CMD_ADD: begin
                            n_state = S_ADD;
                        end
                        CMD_DISPATCH: begin
                            if (!r_run_v) begin
                                n_best  = PRIO_NONE;
                                n_found = 1'b0;
                                n_state = S_DISP;
                            end
                        end
                        CMD_FINISH, CMD_DELAY: begin
                            if (r_run_v) begin
                                n_state = S_RD;
                            end
                        end
                        CMD_DELETE: begin
                            // Free the slot and drop it as the running task
                            if (sel_ok) begin
                                n_used[sel_idx] = 1'b0;
                                n_mode[sel_idx] = MODE_SUSP;
                                if (r_run_v && (r_run_idx == sel_idx)) begin
                                    n_run_v = 1'b0;
                                end
                                n_status = ST_OK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_ADD: begin
                // Scan for the first free slot; sleep and run count start at zero
                if (!r_used[cur_idx]) begin
                    ram_we               = 1'b1;
                    ram_waddr            = cur_idx;
                    ram_wdata.period     = r_per;
                    ram_wdata.priority_val = r_pri;
                    ram_wdata.budget     = r_bud;
                    ram_wdata.start_time = r_now;
                    ram_wdata.sleep      = 32'd0;
                    ram_wdata.runs       = 32'd0;
                    n_used[cur_idx]      = 1'b1;
                    n_mode[cur_idx]      = MODE_READY;
                    n_status             = ST_OK;
                    n_chosen             = 4'(cur_idx);
                    n_state              = S_DONE;
                end else if (r_idx == LAST - (IW + 1)'(1)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + (IW + 1)'(1);
                end
            end

            S_DISP: begin
                // Read slot r_idx while checking slot r_idx - 1 from the RAM output
                if (r_idx != '0) begin
                    if (due) begin
                        ram_we          = 1'b1;
                        ram_waddr       = eval_idx;
                        ram_wdata       = rd;
                        ram_wdata.sleep = 32'd0;
                        n_mode[eval_idx] = MODE_READY;
                    end
                    if (r_used[eval_idx] && (due || (r_mode[eval_idx] == MODE_READY)) &&
                        (rd.priority_val < r_best)) begin
                        n_best     = rd.priority_val;
                        n_pick     = eval_idx;
                        n_found    = 1'b1;
                        n_best_bud = rd.budget;
                    end
                end
                if (r_idx == LAST) begin
                    n_state = S_PICK;
                end else begin
                    n_idx = r_idx + (IW + 1)'(1);
                end
            end

            S_PICK: begin
                // Start the chosen task with its deadline
                if (r_found) begin
                    n_mode[r_pick] = MODE_RUN;
                    n_run_v        = 1'b1;
                    n_run_idx      = r_pick;
                    n_deadline     = r_now + r_best_bud;
                    n_status       = ST_OK;
                    n_chosen       = 4'(r_pick);
                end else begin
                    n_status = ST_NONE;
                end
                n_state = S_DONE;
            end

            S_RD: begin
                ram_raddr = r_run_idx;
                n_state   = S_WR;
            end

            S_WR: begin
                // Write back the running slot with a fresh start time
                ram_we               = 1'b1;
                ram_waddr            = r_run_idx;
                ram_wdata            = rd;
                ram_wdata.start_time = r_now;
                if (r_cmd == CMD_FINISH) begin
                    if (late) begin
                        n_mode[r_run_idx] = MODE_TIMEOUT;
                        n_over            = 1'b1;
                    end else begin
                        n_mode[r_run_idx] = MODE_SUSP;
                        ram_wdata.runs    = rd.runs + 32'd1;
                    end
                    n_run_v = 1'b0;
                end else begin
                    n_mode[r_run_idx] = MODE_SUSP;
                    ram_wdata.sleep   = r_dly;
                end
                n_status = ST_OK;
                n_state  = S_DONE;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            for (int i = 0; i < TASKS; i++) begin
                r_mode[i] <= MODE_SUSP;
            end
            r_run_v    <= 1'b0;
            r_run_idx  <= '0;
            r_deadline <= 32'd0;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_status   <= ST_OK;
            r_chosen   <= 4'd0;
            r_over     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_mode     <= n_mode;
            r_run_v    <= n_run_v;
            r_run_idx  <= n_run_idx;
            r_deadline <= n_deadline;
            r_idx      <= n_idx;
            r_found    <= n_found;
            r_status   <= n_status;
            r_chosen   <= n_chosen;
            r_over     <= n_over;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_now      <= n_now;
        r_per      <= n_per;
        r_pri      <= n_pri;
        r_bud      <= n_bud;
        r_dly      <= n_dly;
        r_best     <= n_best;
        r_pick     <= n_pick;
        r_best_bud <= n_best_bud;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_chosen_slot = r_chosen;
    assign o_overran     = r_over;

endmodule
